@@ hdl/ils_pkg.sv @@
// ils_pkg: shared widths, codes, beat structs and ring address helpers
// for the indexed list store; no dependencies
package ils_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int ENT_W    = 6;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OFF_W    = IDX_W + 1;
  // wide enough for position + 1 and count side by side
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(CAPACITY - 1);

  typedef enum logic [OP_W-1:0] {
    OP_READ      = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_DUMP      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     ok;
    logic                     last;
    logic [ENT_W-1:0]         entries;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              ren;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // ring slot of list offset off, front at fp; callers must keep off at most CAPACITY, unchecked here
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] fp,
                                               input logic [OFF_W-1:0] off);
    logic [OFF_W:0] sum;
    sum = {2'b00, fp} + {1'b0, off};
    if (sum >= (OFF_W + 1)'(CAPACITY)) begin
      sum = sum - (OFF_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] a);
    return (a == SLOT_LAST) ? '0 : a + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? SLOT_LAST : a - IDX_W'(1);
  endfunction

endpackage

@@ hdl/ils_mem.sv @@
// ils_mem: slot storage, one write and one registered read per cycle
// depends on ils_pkg
module ils_mem (
  input  logic                      clk,
  input  ils_pkg::mem_req_t         req,
  output logic [ils_pkg::DATA_W-1:0] rdata
);
  import ils_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.ren) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ hdl/ils_ctrl.sv @@
// ils_ctrl: sequencer, list pointers and the shared ring address unit
// depends on ils_pkg; drives the slot memory in ils_mem
module ils_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  ils_pkg::cmd_t              cmd,
  input  logic [ils_pkg::DATA_W-1:0] rdata,
  output logic                       busy,
  output ils_pkg::mem_req_t          req,
  output logic                       done,
  output ils_pkg::res_t              result
);
  import ils_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] fp, fp_next;
  logic [IDX_W-1:0] last_rd;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             res_load;
  res_t             res_next;

  logic             accept;
  logic [CMP_W-1:0] pos_x, cnt_x, idx_x;
  logic             hit, full, empty, tail_rm, more_shift, more_dump;
  logic [OFF_W-1:0] off;
  logic [IDX_W-1:0] addr_sum;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign pos_x      = CMP_W'(cmd.position);
  assign cnt_x      = CMP_W'(count);
  assign idx_x      = CMP_W'(idx);
  assign hit        = pos_x < cnt_x;
  assign full       = (count == CNT_W'(CAPACITY));
  assign empty      = (count == '0);
  assign tail_rm    = (pos_x + CMP_W'(1)) == cnt_x;
  assign more_shift = (idx_x + CMP_W'(2)) < cnt_x;
  assign more_dump  = (idx_x + CMP_W'(1)) < cnt_x;

  // single ring adder; offset picked by operation
  always_comb begin
    unique case (cmd.operation)
      OP_INS_BACK: off = OFF_W'(count);
      OP_REMOVE:   off = OFF_W'(pos_x + CMP_W'(1));
      OP_DUMP:     off = '0;
      default:     off = OFF_W'(cmd.position);
    endcase
  end
  assign addr_sum = slot_of(fp, off);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.operation)
            OP_READ:   state_next = hit ? ST_READ : ST_IDLE;
            OP_REMOVE: state_next = (hit && !tail_rm) ? ST_SHIFT : ST_IDLE;
            OP_DUMP:   state_next = empty ? ST_IDLE : ST_DUMP;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_SHIFT: state_next = more_shift ? ST_SHIFT : ST_IDLE;
      ST_DUMP:  state_next = more_dump ? ST_DUMP : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath controls and result beat
  always_comb begin
    fp_next    = fp;
    count_next = count;
    idx_next   = idx;
    req        = '0;
    req.wdata  = cmd.data_in;
    res_load   = 1'b0;
    res_next   = '{data_out: '0, ok: 1'b0, last: 1'b1, entries: ENT_W'(count)};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd.operation)
            OP_READ: begin
              if (hit) begin
                req.ren   = 1'b1;
                req.raddr = addr_sum;
              end else begin
                res_load          = 1'b1;
                res_next.data_out = '1;
              end
            end
            OP_INS_FRONT: begin
              res_load = 1'b1;
              if (!full) begin
                fp_next          = ring_dec(fp);
                req.we           = 1'b1;
                req.waddr        = ring_dec(fp);
                count_next       = count + CNT_W'(1);
                res_next.ok      = 1'b1;
                res_next.entries = ENT_W'(count + CNT_W'(1));
              end
            end
            OP_INS_BACK: begin
              res_load = 1'b1;
              if (!full) begin
                req.we           = 1'b1;
                req.waddr        = addr_sum;
                count_next       = count + CNT_W'(1);
                res_next.ok      = 1'b1;
                res_next.entries = ENT_W'(count + CNT_W'(1));
              end
            end
            OP_REMOVE: begin
              if (!hit) begin
                res_load = 1'b1;
              end else if (tail_rm) begin
                res_load         = 1'b1;
                count_next       = count - CNT_W'(1);
                res_next.ok      = 1'b1;
                res_next.entries = ENT_W'(count - CNT_W'(1));
                if (count == CNT_W'(1)) begin
                  fp_next = '0;
                end
              end else begin
                req.ren   = 1'b1;
                req.raddr = addr_sum;
                idx_next  = CNT_W'(cmd.position);
              end
            end
            OP_DUMP: begin
              if (empty) begin
                res_load = 1'b1;
              end else begin
                req.ren   = 1'b1;
                req.raddr = addr_sum;
                idx_next  = '0;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        res_load          = 1'b1;
        res_next.data_out = rdata;
        res_next.ok       = 1'b1;
      end
      ST_SHIFT: begin
        // value from the next slot moves up one place
        req.we    = 1'b1;
        req.waddr = ring_dec(last_rd);
        req.wdata = rdata;
        if (more_shift) begin
          req.ren   = 1'b1;
          req.raddr = ring_inc(last_rd);
          idx_next  = idx + CNT_W'(1);
        end else begin
          res_load         = 1'b1;
          count_next       = count - CNT_W'(1);
          res_next.ok      = 1'b1;
          res_next.entries = ENT_W'(count - CNT_W'(1));
        end
      end
      ST_DUMP: begin
        res_load          = 1'b1;
        res_next.data_out = rdata;
        res_next.ok       = 1'b1;
        res_next.last     = !more_dump;
        if (more_dump) begin
          req.ren   = 1'b1;
          req.raddr = ring_inc(last_rd);
          idx_next  = idx + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fp    <= '0;
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fp    <= fp_next;
      count <= count_next;
      idx   <= idx_next;
      done  <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
    if (req.ren) begin
      last_rd <= req.raddr;
    end
  end

endmodule

@@ hdl/indexed_list_store_unit.sv @@
// indexed_list_store_unit: ordered list of signed values in a ring of slots
// inserts, misses, refusals and tail removal: result registered on acceptance
// read and dump: first beat via the memory read register; dump: one beat per cycle
// removal at position p of n entries: one slot moved per cycle
// the slot memory port (one read, one write a cycle) sets this pace
// sync reset empties the list at once; slot contents are kept, not cleared
module indexed_list_store_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ils_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output ils_pkg::res_t result
);
  import ils_pkg::*;

  // memory request from the sequencer and the registered read data
  mem_req_t          req;
  logic [DATA_W-1:0] rdata;

  // sequencer: decodes the command beat, owns front pointer and count,
  // walks the ring for removal and dump, registers each result beat
  ils_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .rdata  (rdata),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  // slot ring storage
  ils_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

`ifndef SYNTH
  // inserts and unknown codes finish with a single final beat next cycle
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.operation != OP_READ && cmd.operation != OP_REMOVE
     && cmd.operation != OP_DUMP) |=> (done && result.last))
    else $error("single-cycle request did not finish with a final beat");

  // a dump beat that is not final leaves the sequencer working
  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !result.last) |-> busy)
    else $error("non-final beat while idle");

  // a refused or missed request never streams
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (done && !result.ok) |-> result.last)
    else $error("failed beat not marked last");

  // the gap-closing shift never reads the slot it writes
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (req.we && req.ren) |-> (req.waddr != req.raddr))
    else $error("read and write hit the same slot");
`endif

endmodule

@@ bench/ils_result_checker.sv @@
`timescale 1ns / 1ps
// ils_result_checker: watches command and result beats of the list store,
// keeps its own image of the list and checks every result beat in order
// depends on ils_pkg for the beat structs, sizes and operation codes
module ils_result_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  ils_pkg::cmd_t cmd,
  input  logic          done,
  input  ils_pkg::res_t result,
  output int            errors,
  output int            pending,
  output int            checked,
  output int            refusals
);
  import ils_pkg::*;

  logic signed [DATA_W-1:0] image [CAPACITY];
  int unsigned head_slot = 0;
  int unsigned fill = 0;
  int err_count = 0;
  int beat_count = 0;
  int refuse_count = 0;
  res_t expected_beats [$];

  function automatic int unsigned ring_pos(input int unsigned p);
    return (head_slot + p) % CAPACITY;
  endfunction

  // entries field reflects the list length after the command
  function automatic res_t make_beat(input logic signed [DATA_W-1:0] d,
                                     input logic k, input logic l);
    res_t b;
    b.data_out = d;
    b.ok       = k;
    b.last     = l;
    b.entries  = ENT_W'(fill);
    return b;
  endfunction

  // append one predicted beat at the tail of the queue
  function automatic void queue_beat(input res_t b);
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  task automatic predict_command(input cmd_t c);
    int unsigned p;
    int unsigned i;
    p = c.position;
    case (c.operation)
      OP_READ: begin
        if (p < fill) begin
          queue_beat(make_beat(image[ring_pos(p)], 1'b1, 1'b1));
        end else begin
          queue_beat(make_beat(-1, 1'b0, 1'b1));
        end
      end
      OP_INS_FRONT, OP_INS_BACK: begin
        if (fill >= CAPACITY) begin
          refuse_count++;
          queue_beat(make_beat('0, 1'b0, 1'b1));
        end else begin
          if (c.operation == OP_INS_FRONT) begin
            head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
            image[head_slot] = c.data_in;
          end else begin
            image[ring_pos(fill)] = c.data_in;
          end
          fill++;
          queue_beat(make_beat('0, 1'b1, 1'b1));
        end
      end
      OP_REMOVE: begin
        if (p >= fill) begin
          queue_beat(make_beat('0, 1'b0, 1'b1));
        end else begin
          for (i = p; i + 1 < fill; i++) begin
            image[ring_pos(i)] = image[ring_pos(i + 1)];
          end
          fill--;
          if (fill == 0) head_slot = 0;
          queue_beat(make_beat('0, 1'b1, 1'b1));
        end
      end
      OP_DUMP: begin
        if (fill == 0) begin
          queue_beat(make_beat('0, 1'b0, 1'b1));
        end else begin
          for (i = 0; i < fill; i++) begin
            queue_beat(make_beat(image[ring_pos(i)], 1'b1, i + 1 == fill));
          end
        end
      end
      default: begin
        queue_beat(make_beat('0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic check_beat(input res_t got);
    res_t want;
    logic bad;
    bad = 1'b0;
    if (expected_beats.size() == 0) begin
      err_count++;
      $display("%0t: result beat with nothing expected, got data_out %0d ok %0b",
               $time, got.data_out, got.ok);
      $display("%0t:   last %0b entries %0d", $time, got.last, got.entries);
    end else begin
      want = expected_beats.pop_front();
      beat_count++;
      if (got.data_out !== want.data_out) begin
        $display("%0t: data_out expected %0d got %0d", $time, want.data_out, got.data_out);
        bad = 1'b1;
      end
      if (got.ok !== want.ok) begin
        $display("%0t: ok expected %0b got %0b", $time, want.ok, got.ok);
        bad = 1'b1;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        bad = 1'b1;
      end
      if (got.entries !== want.entries) begin
        $display("%0t: entries expected %0d got %0d", $time, want.entries, got.entries);
        bad = 1'b1;
      end
      if (bad) err_count++;
    end
  endtask

  // results come before the command accepted at the same edge
  always @(posedge clk) begin
    if (rst) begin
      head_slot = 0;
      fill = 0;
      expected_beats.delete();
    end else begin
      if (done) check_beat(result);
      if (start && !busy) predict_command(cmd);
    end
    errors   <= err_count;
    pending  <= expected_beats.size();
    checked  <= beat_count;
    refusals <= refuse_count;
  end

endmodule

@@ bench/indexed_list_store_unit_tb.sv @@
`timescale 1ns / 1ps
// indexed_list_store_unit_tb: drives directed and random command beats into
// the list store and gives the verdict; checking lives in ils_result_checker
// depends on ils_pkg, indexed_list_store_unit and ils_result_checker
module indexed_list_store_unit_tb;
  import ils_pkg::*;

  // generous cycle budget: every command at its slowest plus long sender gaps
  localparam int LIMIT     = 400000;
  // longest command: dump of a full store
  localparam int TAIL_WAIT = CAPACITY + 8;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  res_t result;

  int errors;
  int pending;
  int checked;
  int refusals;
  int cycles = 0;
  int sent = 0;
  // chance in a hundred that the sender idles on a given cycle
  int idle_pct = 0;
  int pacing [3] = '{0, 88, 9};

  always #4 clk = ~clk;

  indexed_list_store_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  ils_result_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked),
    .refusals (refusals)
  );

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d result beats still expected", cycles, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // one command beat: hold start until the block takes it, then maybe idle
  // start stays high into the next beat when no gap is drawn
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] val);
    start <= 1'b1;
    cmd   <= '{operation: op, position: pos, data_in: val};
    do @(posedge clk); while (busy);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      // junk on the command bus while start is low must be ignored
      cmd   <= '{operation: OP_W'($urandom), position: POS_W'($urandom),
                 data_in: $urandom};
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  initial begin
    int r;
    int k;
    int phase;
    bit filling;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] val;

    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store corners
    send_cmd(OP_DUMP, '0, '0);
    send_cmd(OP_READ, '0, '0);
    send_cmd(OP_REMOVE, '0, '0);
    // both insert kinds with data extremes
    send_cmd(OP_INS_BACK, '0, DATA_MAX);
    send_cmd(OP_INS_FRONT, '0, DATA_MIN);
    send_cmd(OP_INS_BACK, '1, -1);
    send_cmd(OP_INS_FRONT, '0, '0);
    send_cmd(OP_INS_BACK, 6'd21, 32'sh5A5A_A5A5);
    // reads at the front, the tail, one past the end and the last position
    send_cmd(OP_READ, 6'd0, '0);
    send_cmd(OP_READ, 6'd4, '0);
    send_cmd(OP_READ, 6'd5, '0);
    send_cmd(OP_READ, '1, '0);
    send_cmd(OP_DUMP, '0, '0);
    // middle removal, tail removal, removal far out of range
    send_cmd(OP_REMOVE, 6'd2, '0);
    send_cmd(OP_REMOVE, 6'd3, '0);
    send_cmd(OP_REMOVE, '1, '1);
    // codes past the last operation are ignored
    send_cmd(OP_W'(int'(OP_DUMP) + 1), '1, '1);
    send_cmd(OP_W'(int'(OP_DUMP) + 2), '1, '1);
    send_cmd(OP_W'(int'(OP_DUMP) + 3), '1, '1);
    // drain from the front; the last one removes the only element
    repeat (3) send_cmd(OP_REMOVE, '0, '0);
    send_cmd(OP_READ, '0, '0);
    // front insert after the list went empty again
    send_cmd(OP_INS_FRONT, '0, 32'sh0000_0001);
    send_cmd(OP_DUMP, '0, '0);

    // random: alternate fill and drain runs so the store reaches full
    // and empty many times, at each sender pacing level
    filling = 1'b1;
    k = 0;
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = pacing[phase];
      repeat (119) begin
        if (k % 40 == 39) filling = !filling;
        k++;
        r = $urandom_range(99);
        if (filling) begin
          if (r < 40)      op = OP_INS_FRONT;
          else if (r < 80) op = OP_INS_BACK;
          else if (r < 88) op = OP_READ;
          else if (r < 94) op = OP_REMOVE;
          else if (r < 98) op = OP_DUMP;
          else             op = OP_W'(int'(OP_DUMP) + 1 + $urandom_range(2));
        end else begin
          if (r < 12)      op = OP_INS_FRONT;
          else if (r < 24) op = OP_INS_BACK;
          else if (r < 46) op = OP_READ;
          else if (r < 84) op = OP_REMOVE;
          else if (r < 96) op = OP_DUMP;
          else             op = OP_W'(int'(OP_DUMP) + 1 + $urandom_range(2));
        end
        // positions lean small so most reads and removals hit
        r = $urandom_range(9);
        if (r < 5)      pos = POS_W'($urandom_range(7));
        else if (r < 8) pos = POS_W'($urandom_range(CAPACITY - 1));
        else            pos = POS_W'($urandom_range(63));
        r = $urandom_range(19);
        if (r < 2)       val = DATA_MAX;
        else if (r < 4)  val = DATA_MIN;
        else if (r == 4) val = '0;
        else if (r == 5) val = -1;
        else             val = $urandom;
        send_cmd(op, pos, val);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    // drain: wait for the last beats, then a quiet stretch for strays
    while (pending != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d commands: directed corners, then fill and drain runs at three pacings",
             sent);
    $display("%0d result beats compared, %0d inserts refused on a full store",
             checked, refusals);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d bad beats, %0d beats never arrived", errors, pending);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
